// ----- sv/cph_pkg.sv -----
// Package for the compass heading smoother: widths, angle constants, the
// CORDIC arctangent table and the word types passed between the stages.
// No dependencies.
`default_nettype none

package cph_pkg;

   // CORDIC configuration; the table holds at most TABLE_LEN steps.
   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int CELL_COUNT   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int IDX_W        = $clog2(TABLE_LEN);

   // Field widths.
   localparam int AXIS_W = 16;
   localparam int HEAD_W = 16;
   localparam int GAIN_W = 9;

   // Datapath widths: x and y carry 8 fraction bits plus CORDIC growth;
   // z counts 1/256 of a hundredth of a degree.
   localparam int FRAC_W = 8;
   localparam int XY_W   = 27;
   localparam int Z_W    = 25;
   localparam int ROUND_W = Z_W - FRAC_W;

   // Angle constants in hundredths of a degree.
   localparam int FULL_TURN   = 36000;
   localparam int HALF_TURN   = 18000;
   localparam int HALF_TURN_Z = HALF_TURN * 256;

   // Configuration reset values.
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(51);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE = 2'd0,
      CSR_GAIN   = 2'd1,
      CSR_OFFSET = 2'd2
   } cph_csr_index_type;

   typedef logic signed [AXIS_W-1:0] cph_axis_type;

   // Word moving down the CORDIC chain.
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   zero_vec;
      cph_axis_type           fx;
      cph_axis_type           fy;
      cph_axis_type           fz;
   } cph_cordic_type;

   // Word leaving the smoother: smoothed heading and the echoed axes.
   typedef struct packed {
      logic [HEAD_W-1:0] heading;
      cph_axis_type      fx;
      cph_axis_type      fy;
      cph_axis_type      fz;
   } cph_head_type;

   // atan(2^-i), rounded, in units of 0.01/256 degree.
   function automatic logic signed [Z_W-1:0] atan_step(input logic [IDX_W-1:0] idx);
      logic signed [Z_W-1:0] a;
      unique case (idx)
         5'd0:  a = Z_W'(1152000);
         5'd1:  a = Z_W'(680065);
         5'd2:  a = Z_W'(359328);
         5'd3:  a = Z_W'(182400);
         5'd4:  a = Z_W'(91554);
         5'd5:  a = Z_W'(45822);
         5'd6:  a = Z_W'(22916);
         5'd7:  a = Z_W'(11459);
         5'd8:  a = Z_W'(5730);
         5'd9:  a = Z_W'(2865);
         5'd10: a = Z_W'(1432);
         5'd11: a = Z_W'(716);
         5'd12: a = Z_W'(358);
         5'd13: a = Z_W'(179);
         5'd14: a = Z_W'(90);
         5'd15: a = Z_W'(45);
         5'd16: a = Z_W'(22);
         5'd17: a = Z_W'(11);
         5'd18: a = Z_W'(6);
         5'd19: a = Z_W'(3);
         5'd20: a = Z_W'(1);
         5'd21: a = Z_W'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// ----- sv/cph_ifs.sv -----
// Channel interfaces of the compass heading smoother: sample input, heading
// result and configuration write. Depends on cph_pkg.
`default_nettype none

interface cph_sample_if import cph_pkg::*; ();
   logic         valid;
   logic         ready;
   cph_axis_type sample_x;
   cph_axis_type sample_y;
   cph_axis_type sample_z;

   modport source (output valid, sample_x, sample_y, sample_z, input ready);
   modport sink   (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface cph_result_if import cph_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HEAD_W-1:0] heading;
   cph_axis_type      field_x;
   cph_axis_type      field_y;
   cph_axis_type      field_z;

   modport source (output valid, heading, field_x, field_y, field_z, input ready);
   modport sink   (input valid, heading, field_x, field_y, field_z, output ready);
endinterface

interface cph_csr_if import cph_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [HEAD_W-1:0]    wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ----- sv/cph_cordic_cell.sv -----
// One vectoring CORDIC iteration with its own pipeline register and
// valid/ready handshake. Depends on cph_pkg.
`default_nettype none

module cph_cordic_cell
   import cph_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] step_idx,
   input  wire logic             in_valid,
   output      logic             in_ready,
   input  wire cph_cordic_type   in_data,
   output      logic             out_valid,
   input  wire logic             out_ready,
   output      cph_cordic_type   out_data
);

   logic           valid_ff, valid_in;
   cph_cordic_type data_ff, data_in;

   logic signed [XY_W-1:0] xs, ys;
   logic signed [Z_W-1:0]  ang;

   // The register can take a word when empty or when its word leaves.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Rotate toward the x axis by the step angle.
   always_comb begin
      xs      = in_data.x >>> step_idx;
      ys      = in_data.y >>> step_idx;
      ang     = atan_step(step_idx);
      data_in = in_data;
      if (!in_data.y[XY_W-1]) begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + ang;
      end else begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - ang;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/cph_smoother.sv -----
// Rounds the CORDIC angle to a wrapped heading, then runs the circular
// smoothing filter that holds the smoothed heading. Depends on cph_pkg.
`default_nettype none

module cph_smoother
   import cph_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [GAIN_W-1:0] gain,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire cph_cordic_type    in_data,
   output      logic              out_valid,
   input  wire logic              out_ready,
   output      cph_head_type      out_data
);

   // Rounding stage registers.
   logic              a_valid_ff, a_valid_in;
   logic [HEAD_W-1:0] a_now_ff, a_now_in;
   cph_axis_type      a_fx_ff, a_fy_ff, a_fz_ff;

   // Filter stage registers and filter state.
   logic              b_valid_ff, b_valid_in;
   logic              b_ready;
   cph_axis_type      b_fx_ff, b_fy_ff, b_fz_ff;
   logic              seen_ff, seen_in;
   logic [HEAD_W-1:0] sm_ff, sm_in;

   logic signed [Z_W-1:0]     z_bias;
   logic signed [ROUND_W-1:0] z_round;
   logic signed [17:0]        diff;
   logic signed [27:0]        prod;
   logic        [27:0]        mag;
   logic        [16:0]        q_mag;
   logic signed [17:0]        sum;
   logic                      b_load;

   assign b_ready   = !b_valid_ff || out_ready;
   assign in_ready  = !a_valid_ff || b_ready;
   assign b_load    = a_valid_ff && b_ready;
   assign out_valid = b_valid_ff;
   assign out_data  = '{heading: sm_ff, fx: b_fx_ff, fy: b_fy_ff, fz: b_fz_ff};

   // Round the angle to hundredths of a degree and wrap it into one turn.
   always_comb begin
      z_bias   = in_data.z + Z_W'(128);
      z_round  = ROUND_W'(z_bias >>> FRAC_W);
      a_now_in = HEAD_W'(z_round);
      if (z_round < 0) begin
         a_now_in = HEAD_W'(z_round + ROUND_W'(FULL_TURN));
      end else if (z_round >= ROUND_W'(FULL_TURN)) begin
         a_now_in = HEAD_W'(z_round - ROUND_W'(FULL_TURN));
      end
      if (in_data.zero_vec) begin
         a_now_in = '0;
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (in_ready) begin
         a_valid_in = in_valid;
      end
      b_valid_in = b_valid_ff;
      if (b_ready) begin
         b_valid_in = a_valid_ff;
      end
   end

   // Shortest signed difference, scaled by the gain and rounded half away
   // from zero, then added onto the smoothed heading and wrapped.
   always_comb begin
      diff = $signed({2'b00, a_now_ff}) - $signed({2'b00, sm_ff});
      if (diff > 18'(HALF_TURN)) begin
         diff = diff - 18'(FULL_TURN);
      end else if (diff < -18'(HALF_TURN)) begin
         diff = diff + 18'(FULL_TURN);
      end
      prod  = 28'(diff) * $signed({19'd0, gain});
      mag   = prod[27] ? 28'(-prod) : 28'(prod);
      q_mag = 17'((mag + 28'd128) >> 8);
      if (prod[27]) begin
         sum = $signed({2'b00, sm_ff}) - $signed({1'b0, q_mag});
      end else begin
         sum = $signed({2'b00, sm_ff}) + $signed({1'b0, q_mag});
      end
      if (sum < 0) begin
         sum = sum + 18'(FULL_TURN);
      end else if (sum >= 18'(FULL_TURN)) begin
         sum = sum - 18'(FULL_TURN);
      end
      sm_in   = sm_ff;
      seen_in = seen_ff;
      if (b_load) begin
         seen_in = 1'b1;
         sm_in   = seen_ff ? HEAD_W'(sum) : a_now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         seen_ff    <= 1'b0;
         sm_ff      <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         seen_ff    <= seen_in;
         sm_ff      <= sm_in;
      end
   end

   // Payload registers follow their stage's load.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         a_now_ff <= a_now_in;
         a_fx_ff  <= in_data.fx;
         a_fy_ff  <= in_data.fy;
         a_fz_ff  <= in_data.fz;
      end
      if (b_load) begin
         b_fx_ff <= a_fx_ff;
         b_fy_ff <= a_fy_ff;
         b_fz_ff <= a_fz_ff;
      end
   end

endmodule

`default_nettype wire

// ----- sv/compass_heading_smoother_top.sv -----
// Top level of the compass heading smoother: configuration registers, the
// CORDIC cell chain, the smoother and the output register.
// Depends on cph_pkg, cph_ifs, cph_cordic_cell and cph_smoother.
`default_nettype none

// Takes one magnetometer word (x, y, z) per cycle on req_ch, unless the chain
// is stalled, and returns the smoothed heading, in hundredths of a degree in
// [0, 36000), plus the mounting offset, with the three axes echoed on rsp_ch.
// While the enable register is 0, words are taken and dropped without a
// result. The first word after reset seeds the smoothed heading. A result
// passes a register in each CORDIC cell, one to round the angle, one for the
// smoothing filter and one for the offset and output register. A new word is
// taken every cycle while the output is not stalled; the smoothing filter's
// state loop does not limit this. Each stage holds its word when the next one
// is full, so a stalled result does not stop the words behind it until the
// chain has filled. Configuration writes are always taken and are meant for
// an idle block.

module compass_heading_smoother_top
   import cph_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   cph_sample_if.sink req_ch,
   cph_result_if.source rsp_ch,
   cph_csr_if.sink    csr_ch
);

   // Configuration registers.
   logic              enable_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [HEAD_W-1:0] offset_ff;

   // CORDIC chain links.
   logic           cell_valid [0:CELL_COUNT];
   logic           cell_ready [0:CELL_COUNT];
   cph_cordic_type cell_data  [0:CELL_COUNT];

   // Smoother to output stage.
   logic         sm_valid, sm_ready;
   cph_head_type sm_data;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [HEAD_W-1:0] heading_ff, heading_in;
   cph_axis_type      fx_ff, fy_ff, fz_ff;
   logic [HEAD_W:0]   head_sum;

   // Configuration writes; unknown indexes are ignored.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         gain_ff   <= GAIN_RESET;
         offset_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (cph_csr_index_type'(csr_ch.reg_index))
            CSR_ENABLE: enable_ff <= csr_ch.wdata[0];
            CSR_GAIN:   gain_ff   <= csr_ch.wdata[GAIN_W-1:0];
            CSR_OFFSET: offset_ff <= csr_ch.wdata;
            default: ;
         endcase
      end
   end

   // Scale the sample and fold the left half plane onto the right one.
   always_comb begin
      cell_data[0].x  = {{(XY_W-AXIS_W-FRAC_W){req_ch.sample_x[AXIS_W-1]}},
                         req_ch.sample_x, {FRAC_W{1'b0}}};
      cell_data[0].y  = {{(XY_W-AXIS_W-FRAC_W){req_ch.sample_y[AXIS_W-1]}},
                         req_ch.sample_y, {FRAC_W{1'b0}}};
      cell_data[0].z  = '0;
      cell_data[0].zero_vec = (req_ch.sample_x == '0) && (req_ch.sample_y == '0);
      cell_data[0].fx = req_ch.sample_x;
      cell_data[0].fy = req_ch.sample_y;
      cell_data[0].fz = req_ch.sample_z;
      if (req_ch.sample_x[AXIS_W-1]) begin
         cell_data[0].x = -cell_data[0].x;
         cell_data[0].y = -cell_data[0].y;
         cell_data[0].z = Z_W'(HALF_TURN_Z);
      end
   end

   // Words taken while disabled are dropped at the chain entrance.
   assign cell_valid[0] = req_ch.valid && enable_ff;
   assign req_ch.ready  = cell_ready[0];

   // CORDIC chain, one cell per iteration.
   for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
      cph_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (IDX_W'(k)),
         .in_valid  (cell_valid[k]),
         .in_ready  (cell_ready[k]),
         .in_data   (cell_data[k]),
         .out_valid (cell_valid[k+1]),
         .out_ready (cell_ready[k+1]),
         .out_data  (cell_data[k+1])
      );
   end

   cph_smoother u_smoother (
      .clock     (clock),
      .reset     (reset),
      .gain      (gain_ff),
      .in_valid  (cell_valid[CELL_COUNT]),
      .in_ready  (cell_ready[CELL_COUNT]),
      .in_data   (cell_data[CELL_COUNT]),
      .out_valid (sm_valid),
      .out_ready (sm_ready),
      .out_data  (sm_data)
   );

   // Add the mounting offset and wrap; the sum stays below three turns.
   always_comb begin
      head_sum   = {1'b0, sm_data.heading} + {1'b0, offset_ff};
      heading_in = HEAD_W'(head_sum);
      if (head_sum >= (HEAD_W+1)'(2 * FULL_TURN)) begin
         heading_in = HEAD_W'(head_sum - (HEAD_W+1)'(2 * FULL_TURN));
      end else if (head_sum >= (HEAD_W+1)'(FULL_TURN)) begin
         heading_in = HEAD_W'(head_sum - (HEAD_W+1)'(FULL_TURN));
      end
   end

   assign sm_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (sm_ready) begin
         rsp_valid_in = sm_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sm_valid && sm_ready) begin
         heading_ff <= heading_in;
         fx_ff      <= sm_data.fx;
         fy_ff      <= sm_data.fy;
         fz_ff      <= sm_data.fz;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.heading = heading_ff;
   assign rsp_ch.field_x = fx_ff;
   assign rsp_ch.field_y = fy_ff;
   assign rsp_ch.field_z = fz_ff;

endmodule

`default_nettype wire
